FILE: src/awrc_pkg.sv
// Shared types, constants and the filter term sequence of the A-weighted ring capture.
`default_nettype none
package awrc_pkg;

  localparam int unsigned LEN_W = 11;
  localparam int unsigned SMP_W = 16;
  localparam int unsigned V_W   = 48;
  localparam int unsigned CF_W  = 24;
  localparam int unsigned MAG_W = 50;
  localparam int unsigned ACC_W = 51;
  localparam int unsigned TC_W  = 5;
  localparam logic [TC_W-1:0] LAST_TERM = 5'd16;

  localparam logic signed [V_W-1:0] V_MAX = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [V_W-1:0] V_MIN = 48'sh8000_0000_0000;

  // Register map: one register, selected by paddr[2].
  localparam logic REG_RING_LEN = 1'b0;

  typedef enum logic [1:0] {
    OP_PUSH    = 2'd0,
    OP_READ    = 2'd1,
    OP_DISCARD = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    OPND_DCY,
    OPND_IN,
    OPND_OUT
  } opnd_e;

  typedef enum logic [1:0] {
    BASE_ZERO,
    BASE_DIFF,
    BASE_DLY,
    BASE_ACC
  } base_e;

  typedef enum logic [2:0] {
    DEST_NONE,
    DEST_HP,
    DEST_OUT,
    DEST_DLY,
    DEST_GAIN
  } dest_e;

  typedef struct packed {
    op_e                     op;
    logic signed [SMP_W-1:0] sample;
  } cmd_t;

  typedef struct packed {
    logic signed [CF_W-1:0] coef;
    opnd_e                  opnd;
    base_e                  base;
    dest_e                  dest;
    logic [2:0]             idx;
    logic                   sub;
    logic                   adv;
  } term_t;

  // Q2.22 coefficients.
  localparam logic signed [CF_W-1:0] C_POLE    = 24'sd4190110;
  localparam logic signed [CF_W-1:0] C_S1_B0   = 24'sd709257;
  localparam logic signed [CF_W-1:0] C_S1_B1   = -24'sd887515;
  localparam logic signed [CF_W-1:0] C_S1_B2   = 24'sd178258;
  localparam logic signed [CF_W-1:0] C_S1_NA1  = 24'sd7830346;
  localparam logic signed [CF_W-1:0] C_S1_A2   = 24'sd3670855;
  localparam logic signed [CF_W-1:0] C_ONE     = 24'sd4194304;
  localparam logic signed [CF_W-1:0] C_MTWO    = -24'sd8388608;
  localparam logic signed [CF_W-1:0] C_S2_NA1  = 24'sd7904166;
  localparam logic signed [CF_W-1:0] C_S2_A2   = 24'sd3723703;
  localparam logic signed [CF_W-1:0] C_S3_NA1  = 24'sd8348343;
  localparam logic signed [CF_W-1:0] C_S3_A2   = 24'sd4154458;
  localparam logic signed [CF_W-1:0] C_GAIN    = 24'sd4823450;

  function automatic term_t mk(input logic signed [CF_W-1:0] coef, input opnd_e opnd,
                               input base_e base, input dest_e dest, input logic [2:0] idx,
                               input logic sub, input logic adv);
    term_t t;
    t.coef = coef;
    t.opnd = opnd;
    t.base = base;
    t.dest = dest;
    t.idx  = idx;
    t.sub  = sub;
    t.adv  = adv;
    return t;
  endfunction

  // One multiply-accumulate term per step: DC blocker, three biquads of five terms, gain.
  function automatic term_t term_of(input logic [TC_W-1:0] tc);
    term_t t;
    case (tc)
      5'd0:  t = mk(C_POLE,   OPND_DCY, BASE_DIFF, DEST_HP,   3'd0, 1'b0, 1'b0);
      5'd1:  t = mk(C_S1_B0,  OPND_IN,  BASE_DLY,  DEST_OUT,  3'd0, 1'b0, 1'b0);
      5'd2:  t = mk(C_S1_B1,  OPND_IN,  BASE_DLY,  DEST_NONE, 3'd1, 1'b0, 1'b0);
      5'd3:  t = mk(C_S1_NA1, OPND_OUT, BASE_ACC,  DEST_DLY,  3'd0, 1'b0, 1'b0);
      5'd4:  t = mk(C_S1_B2,  OPND_IN,  BASE_ZERO, DEST_NONE, 3'd0, 1'b0, 1'b0);
      5'd5:  t = mk(C_S1_A2,  OPND_OUT, BASE_ACC,  DEST_DLY,  3'd1, 1'b1, 1'b1);
      5'd6:  t = mk(C_ONE,    OPND_IN,  BASE_DLY,  DEST_OUT,  3'd2, 1'b0, 1'b0);
      5'd7:  t = mk(C_MTWO,   OPND_IN,  BASE_DLY,  DEST_NONE, 3'd3, 1'b0, 1'b0);
      5'd8:  t = mk(C_S2_NA1, OPND_OUT, BASE_ACC,  DEST_DLY,  3'd2, 1'b0, 1'b0);
      5'd9:  t = mk(C_ONE,    OPND_IN,  BASE_ZERO, DEST_NONE, 3'd2, 1'b0, 1'b0);
      5'd10: t = mk(C_S2_A2,  OPND_OUT, BASE_ACC,  DEST_DLY,  3'd3, 1'b1, 1'b1);
      5'd11: t = mk(C_ONE,    OPND_IN,  BASE_DLY,  DEST_OUT,  3'd4, 1'b0, 1'b0);
      5'd12: t = mk(C_MTWO,   OPND_IN,  BASE_DLY,  DEST_NONE, 3'd5, 1'b0, 1'b0);
      5'd13: t = mk(C_S3_NA1, OPND_OUT, BASE_ACC,  DEST_DLY,  3'd4, 1'b0, 1'b0);
      5'd14: t = mk(C_ONE,    OPND_IN,  BASE_ZERO, DEST_NONE, 3'd4, 1'b0, 1'b0);
      5'd15: t = mk(C_S3_A2,  OPND_OUT, BASE_ACC,  DEST_DLY,  3'd5, 1'b1, 1'b1);
      default: t = mk(C_GAIN, OPND_IN,  BASE_ZERO, DEST_GAIN, 3'd0, 1'b0, 1'b0);
    endcase
    return t;
  endfunction

endpackage
`default_nettype wire

FILE: src/awrc_front.sv
// Front end: accepts input beats, drops unknown operations and queues commands.
`default_nettype none
module awrc_front (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output      logic             in_stall_o,
  input  wire logic [1:0]       operation_i,
  input  wire logic signed [15:0] raw_sample_i,
  output      logic             cmd_valid_o,
  output      awrc_pkg::cmd_t   cmd_o,
  input  wire logic             cmd_pop_i
);

  awrc_pkg::cmd_t q_q [2];
  logic [1:0] cnt_q, cnt_d;
  logic       wr_q, rd_q;
  logic       known, enq, deq;

  assign known = (operation_i == awrc_pkg::OP_PUSH) || (operation_i == awrc_pkg::OP_READ) ||
                 (operation_i == awrc_pkg::OP_DISCARD);
  assign in_stall_o  = (cnt_q == 2'd2);
  assign enq         = in_valid_i && !in_stall_o && known;
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign deq         = cmd_pop_i && cmd_valid_o;
  assign cmd_o       = q_q[rd_q];

  always_comb begin
    cnt_d = cnt_q;
    if (enq && !deq) begin
      cnt_d = cnt_q + 2'd1;
    end else if (deq && !enq) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (enq) begin
        wr_q <= !wr_q;
      end
      if (deq) begin
        rd_q <= !rd_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (enq) begin
      q_q[wr_q].op     <= awrc_pkg::op_e'(operation_i);
      q_q[wr_q].sample <= raw_sample_i;
    end
  end

endmodule
`default_nettype wire

FILE: src/awrc_back.sv
// Back end: filter sequencer on a shared multiplier, sample ring and result register.
`default_nettype none
module awrc_back #(
  parameter int unsigned RING_DEPTH = 1024
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                cmd_valid_i,
  input  wire awrc_pkg::cmd_t                      cmd_i,
  output      logic                                cmd_pop_o,
  input  wire logic                                cfg_wr_i,
  input  wire logic [awrc_pkg::LEN_W-1:0]          ring_len_i,
  output      logic                                out_valid_o,
  input  wire logic                                out_stall_i,
  output      logic signed [awrc_pkg::SMP_W-1:0]   read_sample_o,
  output      logic                                read_valid_o,
  output      logic [awrc_pkg::LEN_W-1:0]          stored_count_o
);

  localparam int unsigned AW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int unsigned LW = awrc_pkg::LEN_W;
  localparam int unsigned VW = awrc_pkg::V_W;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_LOAD  = 3'd1;
  localparam logic [2:0] S_MLO   = 3'd2;
  localparam logic [2:0] S_MHI   = 3'd3;
  localparam logic [2:0] S_ACC   = 3'd4;
  localparam logic [2:0] S_WRITE = 3'd5;
  localparam logic [2:0] S_READ  = 3'd6;

  logic [2:0] st_q;
  logic [awrc_pkg::TC_W-1:0] tc_q;

  logic signed [15:0]   dcx_q;
  logic signed [VW-1:0] dcy_q, cur_q, bo_q;
  logic signed [VW-1:0] dly_q [6];
  logic signed [awrc_pkg::ACC_W-1:0] acc_q, diff_q;
  logic [VW-1:0]        mv_q;
  logic [23:0]          mc_q;
  logic                 neg_q;
  logic [47:0]          plo_q;
  logic [awrc_pkg::MAG_W-1:0] mag_q;

  logic [LW-1:0] wr_q, rd_q, fill_q;
  logic signed [15:0] mem [RING_DEPTH];
  logic signed [15:0] rdata_q;

  awrc_pkg::term_t term;
  logic signed [VW-1:0] opv;
  logic [47:0]  phi;
  logic [71:0]  full;
  logic signed [48:0] tv, tvs;
  logic signed [awrc_pkg::ACC_W-1:0] sum;
  logic signed [VW-1:0] s48;
  logic signed [16:0]   dsm;
  logic signed [32:0]   ip;
  logic signed [15:0]   y16;
  logic [LW-1:0] wr_inc, rd_inc;
  logic out_free;

  assign term     = awrc_pkg::term_of(tc_q);
  assign out_free = !out_valid_o || !out_stall_i;
  assign cmd_pop_o = (st_q == S_IDLE) && cmd_valid_i;
  assign wr_inc = (wr_q + LW'(1) >= ring_len_i) ? '0 : wr_q + LW'(1);
  assign rd_inc = (rd_q + LW'(1) >= ring_len_i) ? '0 : rd_q + LW'(1);
  assign dsm = 17'(cmd_i.sample) - 17'(dcx_q);

  always_comb begin
    case (term.opnd)
      awrc_pkg::OPND_DCY: opv = dcy_q;
      awrc_pkg::OPND_OUT: opv = bo_q;
      default:            opv = cur_q;
    endcase
  end

  // One 24x24 multiplier: the low half of the operand in S_MLO, the high half in S_MHI.
  assign phi  = ((st_q == S_MLO) ? mv_q[23:0] : mv_q[47:24]) * mc_q;
  assign full = {phi, 24'd0} + {24'd0, plo_q} + 72'd2097152;

  // Signed, saturated term and the running sum.
  always_comb begin
    if (neg_q) begin
      tv = (mag_q >= 50'h0_8000_0000_0000) ? 49'(awrc_pkg::V_MIN)
                                           : -$signed({2'b00, mag_q[46:0]});
    end else begin
      tv = (mag_q >= 50'h0_8000_0000_0000) ? 49'(awrc_pkg::V_MAX)
                                           : $signed({2'b00, mag_q[46:0]});
    end
    tvs = term.sub ? -tv : tv;
    sum = acc_q + {{2{tvs[48]}}, tvs};
    if (sum > 51'(awrc_pkg::V_MAX)) begin
      s48 = awrc_pkg::V_MAX;
    end else if (sum < 51'(awrc_pkg::V_MIN)) begin
      s48 = awrc_pkg::V_MIN;
    end else begin
      s48 = sum[47:0];
    end
  end

  // Truncation toward zero to an integer, then saturation to 16 bits.
  always_comb begin
    ip = 33'($signed(cur_q[47:16])) +
         33'((cur_q[47] && (cur_q[15:0] != 16'd0)) ? 1 : 0);
    if (ip > 33'sd32767) begin
      y16 = 16'sh7FFF;
    end else if (ip < -33'sd32768) begin
      y16 = 16'sh8000;
    end else begin
      y16 = ip[15:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= S_IDLE;
      tc_q        <= '0;
      dcx_q       <= '0;
      dcy_q       <= '0;
      for (int i = 0; i < 6; i++) begin
        dly_q[i] <= '0;
      end
      wr_q        <= '0;
      rd_q        <= '0;
      fill_q      <= '0;
      out_valid_o <= 1'b0;
    end else begin
      if (st_q == S_READ && out_free) begin
        out_valid_o <= 1'b1;
      end else if (out_valid_o && !out_stall_i) begin
        out_valid_o <= 1'b0;
      end
      if (cfg_wr_i) begin
        wr_q   <= '0;
        rd_q   <= '0;
        fill_q <= '0;
      end
      case (st_q)
        S_IDLE: begin
          if (cmd_valid_i) begin
            case (cmd_i.op)
              awrc_pkg::OP_PUSH: begin
                dcx_q <= cmd_i.sample;
                tc_q  <= '0;
                st_q  <= S_LOAD;
              end
              awrc_pkg::OP_READ: begin
                st_q <= S_READ;
              end
              default: begin
                rd_q   <= wr_q;
                fill_q <= '0;
              end
            endcase
          end
        end
        S_LOAD:  st_q <= S_MLO;
        S_MLO:   st_q <= S_MHI;
        S_MHI:   st_q <= S_ACC;
        S_ACC: begin
          case (term.dest)
            awrc_pkg::DEST_HP: begin
              dcy_q <= s48;
              cur_q <= s48;
            end
            awrc_pkg::DEST_OUT:  bo_q  <= s48;
            awrc_pkg::DEST_DLY: begin
              dly_q[term.idx] <= s48;
              if (term.adv) begin
                cur_q <= bo_q;
              end
            end
            awrc_pkg::DEST_GAIN: cur_q <= s48;
            default: ;
          endcase
          if (tc_q == awrc_pkg::LAST_TERM) begin
            st_q <= S_WRITE;
          end else begin
            tc_q <= tc_q + 1'b1;
            st_q <= S_LOAD;
          end
        end
        S_WRITE: begin
          wr_q <= wr_inc;
          if (fill_q < ring_len_i) begin
            fill_q <= fill_q + LW'(1);
          end else begin
            rd_q <= rd_inc;
          end
          st_q <= S_IDLE;
        end
        S_READ: begin
          if (out_free) begin
            if (fill_q != '0) begin
              rd_q   <= rd_inc;
              fill_q <= fill_q - LW'(1);
            end
            st_q <= S_IDLE;
          end
        end
        default: st_q <= S_IDLE;
      endcase
    end
  end

  // Datapath registers without reset.
  always_ff @(posedge clk_i) begin
    if (st_q == S_IDLE) begin
      diff_q <= {{(awrc_pkg::ACC_W-33){dsm[16]}}, dsm, 16'd0};
    end
    if (st_q == S_LOAD) begin
      neg_q <= term.coef[23] ^ opv[47];
      mv_q  <= opv[47] ? 48'(-opv) : opv;
      mc_q  <= term.coef[23] ? 24'(-term.coef) : term.coef;
      case (term.base)
        awrc_pkg::BASE_DIFF: acc_q <= diff_q;
        awrc_pkg::BASE_DLY:  acc_q <= {{3{dly_q[term.idx][47]}}, dly_q[term.idx]};
        awrc_pkg::BASE_ACC:  acc_q <= acc_q;
        default:             acc_q <= '0;
      endcase
    end
    if (st_q == S_MLO) begin
      plo_q <= phi;
    end
    if (st_q == S_MHI) begin
      mag_q <= full[71:22];
    end
    if (st_q == S_ACC && term.dest == awrc_pkg::DEST_NONE) begin
      acc_q <= sum;
    end
    if (st_q == S_READ && out_free) begin
      if (fill_q != '0) begin
        read_sample_o  <= rdata_q;
        read_valid_o   <= 1'b1;
        stored_count_o <= fill_q - LW'(1);
      end else begin
        read_sample_o  <= '0;
        read_valid_o   <= 1'b0;
        stored_count_o <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_q == S_WRITE) begin
      mem[AW'(wr_q)] <= y16;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[AW'(rd_q)];
  end

endmodule
`default_nettype wire

FILE: src/a_weighted_audio_ring_capture_core.sv
// Top level of the A-weighted audio ring capture: APB register, front end and back end.
//
// Input beats carry an operation and a raw 16-bit sample on in_valid_i/in_stall_o.
// A push runs the sample through a DC blocker, three biquads and a gain of 1.15 in
// 48-bit fixed point, saturates it to 16 bits and stores it in the ring. A read
// pops the oldest stored sample and returns one result beat on out_valid_o /
// out_stall_i; a discard empties the ring. Unknown operations are dropped.
// The front end holds up to two commands, so in_stall_o rises only when both
// queue slots are taken while the back end works.
// A push occupies the back end for 17 multiply-accumulate terms, each stepping
// through S_LOAD, S_MLO, S_MHI and S_ACC on one shared 24x24 multiplier, plus
// issue and ring write, and the next command waits until it is done; a read
// passes S_READ into the registered result beat; a discard is done in S_IDLE.
// A stalled result stays in the output register; the next read waits for it,
// while pushes and discards keep going.
// Reset clears the filter state, the ring positions and the fill count and sets
// ring_length to 1024 (or RING_DEPTH if smaller). Writing ring_length empties the
// ring and keeps the filter state; it is clamped to 1..LEN_MAX (RING_DEPTH, at most 2047).
`default_nettype none
module a_weighted_audio_ring_capture_core #(
  parameter int unsigned RING_DEPTH = 1024
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output      logic                in_stall_o,
  input  wire logic [1:0]          operation_i,
  input  wire logic signed [15:0]  raw_sample_i,
  output      logic                out_valid_o,
  input  wire logic                out_stall_i,
  output      logic signed [15:0]  read_sample_o,
  output      logic                read_valid_o,
  output      logic [10:0]         stored_count_o,
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [2:0]          paddr,
  input  wire logic [31:0]         pwdata,
  output      logic [31:0]         prdata,
  output      logic                pready
);

  localparam int unsigned LW = awrc_pkg::LEN_W;
  // Largest usable length: the register is 11 bits wide.
  localparam int unsigned LEN_MAX = (RING_DEPTH < 2047) ? RING_DEPTH : 2047;
  localparam int unsigned LEN_RST = (RING_DEPTH < 1024) ? RING_DEPTH : 1024;

  logic [LW-1:0] len_q, len_d;
  logic          cfg_wr;
  logic          cmd_valid, cmd_pop;
  awrc_pkg::cmd_t cmd;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == awrc_pkg::REG_RING_LEN);
  assign prdata = (paddr[2] == awrc_pkg::REG_RING_LEN) ? {21'd0, len_q} : 32'd0;

  // Clamp the written length into 1..LEN_MAX.
  always_comb begin
    if (pwdata[10:0] == 11'd0) begin
      len_d = LW'(1);
    end else if (pwdata[10:0] > LW'(LEN_MAX)) begin
      len_d = LW'(LEN_MAX);
    end else begin
      len_d = pwdata[10:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= LW'(LEN_RST);
    end else if (cfg_wr) begin
      len_q <= len_d;
    end
  end

  awrc_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .operation_i  (operation_i),
    .raw_sample_i (raw_sample_i),
    .cmd_valid_o  (cmd_valid),
    .cmd_o        (cmd),
    .cmd_pop_i    (cmd_pop)
  );

  awrc_back #(
    .RING_DEPTH (RING_DEPTH)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_valid_i    (cmd_valid),
    .cmd_i          (cmd),
    .cmd_pop_o      (cmd_pop),
    .cfg_wr_i       (cfg_wr),
    .ring_len_i     (len_q),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .read_sample_o  (read_sample_o),
    .read_valid_o   (read_valid_o),
    .stored_count_o (stored_count_o)
  );

endmodule
`default_nettype wire

FILE: src/awrc_checker.sv
// Port-level assertions for the A-weighted ring capture, bound to the top level.
`default_nettype none
module awrc_checker #(
  parameter int unsigned RING_DEPTH = 1024
) (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               out_valid_o,
  input wire logic               out_stall_i,
  input wire logic signed [15:0] read_sample_o,
  input wire logic               read_valid_o,
  input wire logic [10:0]        stored_count_o,
  input wire logic               pready
);

  // A stalled result beat holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(read_sample_o) &&
    $stable(read_valid_o) && $stable(stored_count_o))
    else $error("result beat changed while stalled");

  // An empty read returns zeros.
  a_empty_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !read_valid_o |-> read_sample_o == 16'sd0 && stored_count_o == 11'd0)
    else $error("empty read carries data");

  // After a pop the ring holds fewer samples than its depth.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && read_valid_o |-> 32'(stored_count_o) < RING_DEPTH)
    else $error("stored count beyond ring depth");

  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni) pready)
    else $error("register port not ready");

endmodule

bind a_weighted_audio_ring_capture_core awrc_checker #(
  .RING_DEPTH (RING_DEPTH)
) u_awrc_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .read_sample_o  (read_sample_o),
  .read_valid_o   (read_valid_o),
  .stored_count_o (stored_count_o),
  .pready         (pready)
);
`default_nettype wire

FILE: tb/a_weighted_audio_ring_capture_core_test.sv
// Self-checking testbench of the A-weighted audio ring capture core.
`default_nettype none
module a_weighted_audio_ring_capture_core_test;

  // Depth of the ring in the block under test.
  localparam int unsigned DEPTH = 1024;
  // Wait after the last read beat so that the back end finishes the pushes still queued.
  localparam int unsigned DRAIN_CYCLES = 400;
  // Cycles without any accepted beat or register access before the run is declared hung.
  localparam int unsigned HANG_LIMIT = 20000;
  // Operation code with no meaning; the block drops it.
  localparam logic [1:0] OP_RESERVED = 2'd3;

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_stall_o;
  logic [1:0] operation_i;
  logic signed [15:0] raw_sample_i;
  logic out_valid_o;
  logic out_stall_i;
  logic signed [15:0] read_sample_o;
  logic read_valid_o;
  logic [10:0] stored_count_o;
  logic psel;
  logic penable;
  logic pwrite;
  logic [2:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  a_weighted_audio_ring_capture_core #(.RING_DEPTH(DEPTH)) uut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o),
    .operation_i(operation_i), .raw_sample_i(raw_sample_i),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i),
    .read_sample_o(read_sample_o), .read_valid_o(read_valid_o),
    .stored_count_o(stored_count_o),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // One expected read beat.
  typedef struct {
    logic signed [15:0] sample;
    logic               valid;
    logic [10:0]        count;
  } read_beat_t;

  localparam logic signed [47:0] Q_MAX = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [47:0] Q_MIN = 48'sh8000_0000_0000;

  // Shadow copy of the filter and ring state.
  logic signed [15:0] hp_last_in;
  logic signed [47:0] hp_last_out;
  logic signed [47:0] sec_state [6];
  logic signed [15:0] shadow_ring [DEPTH];
  int unsigned        wr_pos;
  int unsigned        rd_pos;
  int unsigned        held;
  int unsigned        ring_len;

  read_beat_t pending_reads[$];
  int unsigned failures;
  int unsigned quiet_cycles;
  int unsigned send_gap_pct;
  int unsigned stall_pct;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic logic signed [47:0] clamp48(input logic signed [63:0] v);
    if (v > 64'(Q_MAX)) return Q_MAX;
    if (v < 64'(Q_MIN)) return Q_MIN;
    return v[47:0];
  endfunction

  // Q2.22 coefficient times Q.16 value; the magnitude is rounded half away from zero.
  function automatic logic signed [47:0] coef_mul(input logic signed [23:0] c,
                                                  input logic signed [47:0] v);
    logic        neg;
    logic [63:0] mc;
    logic [63:0] mv;
    logic [63:0] mag;
    neg = (c < 0) != (v < 0);
    mc = (c < 0) ? 64'(-64'(c)) : 64'(c);
    mv = (v < 0) ? 64'(-64'(v)) : 64'(v);
    mag = (mv >> 22) * mc + (((mv & 64'h3F_FFFF) * mc + 64'h20_0000) >> 22);
    if (neg) begin
      if (mag >= (64'd1 << 47)) return Q_MIN;
      return -$signed(mag[47:0]);
    end
    if (mag > 64'(Q_MAX)) return Q_MAX;
    return mag[47:0];
  endfunction

  function automatic logic signed [47:0] run_section(input logic signed [47:0] x, input int k,
      input logic signed [23:0] b0, input logic signed [23:0] b1, input logic signed [23:0] b2,
      input logic signed [23:0] na1, input logic signed [23:0] a2);
    logic signed [47:0] y;
    y = clamp48(64'(coef_mul(b0, x)) + 64'(sec_state[k]));
    sec_state[k] = clamp48(64'(coef_mul(b1, x)) + 64'(coef_mul(na1, y)) + 64'(sec_state[k+1]));
    sec_state[k+1] = clamp48(64'(coef_mul(b2, x)) - 64'(coef_mul(a2, y)));
    return y;
  endfunction

  function automatic logic signed [15:0] weigh_sample(input logic signed [15:0] s);
    logic signed [47:0] v;
    logic signed [63:0] whole;
    v = clamp48(64'(s) * 65536 - 64'(hp_last_in) * 65536 +
                64'(coef_mul(awrc_pkg::C_POLE, hp_last_out)));
    hp_last_in = s;
    hp_last_out = v;
    v = run_section(v, 0, awrc_pkg::C_S1_B0, awrc_pkg::C_S1_B1, awrc_pkg::C_S1_B2,
                    awrc_pkg::C_S1_NA1, awrc_pkg::C_S1_A2);
    v = run_section(v, 2, awrc_pkg::C_ONE, awrc_pkg::C_MTWO, awrc_pkg::C_ONE,
                    awrc_pkg::C_S2_NA1, awrc_pkg::C_S2_A2);
    v = run_section(v, 4, awrc_pkg::C_ONE, awrc_pkg::C_MTWO, awrc_pkg::C_ONE,
                    awrc_pkg::C_S3_NA1, awrc_pkg::C_S3_A2);
    v = coef_mul(awrc_pkg::C_GAIN, v);
    whole = (v < 0) ? -((-64'(v)) / 65536) : (64'(v) / 65536);
    if (whole > 32767) whole = 32767;
    if (whole < -32768) whole = -32768;
    return whole[15:0];
  endfunction

  // Updates the shadow state for one accepted command beat.
  function automatic void track_command(input logic [1:0] op, input logic signed [15:0] s);
    read_beat_t r;
    if (op == awrc_pkg::OP_PUSH) begin
      if (wr_pos >= ring_len) wr_pos = 0;
      shadow_ring[wr_pos] = weigh_sample(s);
      wr_pos++;
      if (wr_pos >= ring_len) wr_pos = 0;
      if (held < ring_len) begin
        held++;
      end else begin
        rd_pos++;
        if (rd_pos >= ring_len) rd_pos = 0;
      end
    end else if (op == awrc_pkg::OP_READ) begin
      if (held == 0) begin
        r.sample = '0;
        r.valid = 1'b0;
        r.count = '0;
      end else begin
        if (rd_pos >= ring_len) rd_pos = 0;
        r.sample = shadow_ring[rd_pos];
        r.valid = 1'b1;
        rd_pos++;
        if (rd_pos >= ring_len) rd_pos = 0;
        held--;
        r.count = held[10:0];
      end
      pending_reads.push_back(r);
    end else if (op == awrc_pkg::OP_DISCARD) begin
      rd_pos = wr_pos;
      held = 0;
    end
  endfunction

  task automatic report_mismatch(input string what);
    $display("mismatch at %0t: %s", $time, what);
    failures++;
  endtask

  // Result checker, stall generator and hang watchdog.
  always @(posedge clk_i) begin
    read_beat_t e;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (pending_reads.size() == 0) begin
          report_mismatch("read beat with nothing expected");
        end else begin
          e = pending_reads.pop_front();
          if (read_sample_o !== e.sample)
            report_mismatch($sformatf("read_sample %0d, want %0d", read_sample_o, e.sample));
          if (read_valid_o !== e.valid)
            report_mismatch($sformatf("read_valid %0b, want %0b", read_valid_o, e.valid));
          if (stored_count_o !== e.count)
            report_mismatch($sformatf("stored_count %0d, want %0d", stored_count_o, e.count));
        end
      end
      if ((out_valid_o && !out_stall_i) || (in_valid_i && !in_stall_o) || psel)
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= HANG_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
    out_stall_i <= ($urandom_range(99) < stall_pct);
  end

  // Sends one command beat, with a random idle gap first. The beat stays up after
  // acceptance until the next command or an idle cycle replaces it.
  task automatic send_command(input logic [1:0] op, input logic signed [15:0] s);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    operation_i <= op;
    raw_sample_i <= s;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    track_command(op, s);
  endtask

  // Waits until every read beat has come back and the back end has gone idle.
  task automatic settle;
    in_valid_i <= 1'b0;
    while (pending_reads.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // APB register write in setup and access phases; the block empties its ring on each write.
  task automatic set_ring_length(input logic [10:0] len);
    int unsigned n;
    settle();
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= '0;
    pwdata <= 32'(len);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    n = len;
    if (n < 1) n = 1;
    if (n > DEPTH) n = DEPTH;
    ring_len = n;
    wr_pos = 0;
    rd_pos = 0;
    held = 0;
    @(posedge clk_i);
  endtask

  function automatic logic signed [15:0] any_sample();
    return 16'($urandom);
  endfunction

  // Extremes, every operation and the special cases of the ring.
  task automatic test_directed;
    send_command(awrc_pkg::OP_READ, 16'sd0);
    send_command(awrc_pkg::OP_PUSH, 16'sh7FFF);
    send_command(awrc_pkg::OP_PUSH, 16'sh8000);
    send_command(awrc_pkg::OP_PUSH, 16'sh7FFF);
    send_command(awrc_pkg::OP_PUSH, 16'sh8000);
    send_command(awrc_pkg::OP_PUSH, 16'sh0000);
    send_command(awrc_pkg::OP_PUSH, 16'shFFFF);
    send_command(awrc_pkg::OP_READ, 16'sh7FFF);
    send_command(OP_RESERVED, 16'sh1234);
    send_command(awrc_pkg::OP_READ, 16'sd0);
    send_command(awrc_pkg::OP_DISCARD, 16'sd0);
    send_command(awrc_pkg::OP_READ, 16'sd0);
    set_ring_length(11'd1);
    send_command(awrc_pkg::OP_PUSH, 16'sh5555);
    send_command(awrc_pkg::OP_PUSH, 16'shAAAA);
    send_command(awrc_pkg::OP_READ, 16'sd0);
    send_command(awrc_pkg::OP_READ, 16'sd0);
    set_ring_length(11'd0);
    send_command(awrc_pkg::OP_PUSH, 16'sh7FFF);
    send_command(awrc_pkg::OP_READ, 16'sd0);
    set_ring_length(11'h7FF);
    send_command(awrc_pkg::OP_PUSH, 16'sh8000);
    send_command(awrc_pkg::OP_READ, 16'sd0);
  endtask

  // Random mix; pushes dominate so small rings wrap often, reads keep results flowing.
  task automatic test_random_phase(input logic [10:0] len, input int unsigned items,
                                   input int unsigned gap, input int unsigned stall);
    int unsigned pick;
    set_ring_length(len);
    send_gap_pct = gap;
    stall_pct = stall;
    repeat (items) begin
      pick = $urandom_range(99);
      if (pick < 55) send_command(awrc_pkg::OP_PUSH, any_sample());
      else if (pick < 92) send_command(awrc_pkg::OP_READ, any_sample());
      else if (pick < 97) send_command(awrc_pkg::OP_DISCARD, any_sample());
      else send_command(OP_RESERVED, any_sample());
    end
    send_gap_pct = 0;
    stall_pct = 0;
  endtask

  initial begin
    failures = 0;
    quiet_cycles = 0;
    send_gap_pct = 0;
    stall_pct = 0;
    hp_last_in = '0;
    hp_last_out = '0;
    foreach (sec_state[i]) sec_state[i] = '0;
    foreach (shadow_ring[i]) shadow_ring[i] = '0;
    wr_pos = 0;
    rd_pos = 0;
    held = 0;
    ring_len = DEPTH;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    operation_i = awrc_pkg::OP_PUSH;
    raw_sample_i = '0;
    out_stall_i = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_random_phase(11'd1024, 300, 0, 0);
    test_random_phase(11'd7, 300, 48, 0);
    test_random_phase(11'd3, 300, 0, 48);
    test_random_phase(11'd1, 150, 37, 37);
    test_random_phase(11'd1023, 150, 37, 37);

    settle();
    if (failures == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
`default_nettype wire
